// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- hw/rtl/p2ba_pkg.sv -----
// Shared types and codes of the power-of-two block allocator.
// Depends on nothing; used by the controller, datapath and top level.
`default_nettype none
package p2ba_pkg;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_NO_PAGE = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;
    localparam int MAX_CLASSES = 16;
    localparam int CLASS_W = 4;
    localparam int COUNT_W = 15;

    typedef struct packed {
        logic latch;
        logic find_class;
        logic scan_page;
        logic claim_page;
        logic cut_step;
        logic link_read;
        logic pop;
        logic free_push;
        logic clear_step;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic too_large;
        logic class_found;
        logic head_empty;
        logic page_hit;
        logic page_end;
        logic cut_last;
        logic free_bad;
        logic free_zero;
        logic clear_last;
    } t_stat;
endpackage
`default_nettype wire

// ----- hw/rtl/p2ba_ctrl.sv -----
// Controller state machine of the allocator.
// Depends on p2ba_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module p2ba_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  p2ba_pkg::t_stat      i_stat,
    output logic                 o_busy,
    output p2ba_pkg::t_cmd       o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_CLASS = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_CUT = 4'd4;
    localparam logic [3:0] S_LINK = 4'd5;
    localparam logic [3:0] S_POP = 4'd6;
    localparam logic [3:0] S_FREE = 4'd7;
    localparam logic [3:0] S_CLEAR = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.mode) begin
                    n_state = S_FREE;
                end else if (i_stat.too_large) begin
                    o_cmd.done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                o_cmd.find_class = 1'b1;
                if (i_stat.class_found) begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                if (i_stat.head_empty) begin
                    n_state = S_SCAN;
                end else begin
                    o_cmd.link_read = 1'b1;
                    n_state = S_POP;
                end
            end
            S_SCAN: begin
                o_cmd.scan_page = 1'b1;
                if (i_stat.page_hit) begin
                    o_cmd.claim_page = 1'b1;
                    n_state = S_CUT;
                end else if (i_stat.page_end) begin
                    o_cmd.done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CUT: begin
                o_cmd.cut_step = 1'b1;
                if (i_stat.cut_last) begin
                    n_state = S_LINK;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state = S_DONE;
            end
            S_FREE: begin
                if (i_stat.free_bad) begin
                    o_cmd.done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.free_push = 1'b1;
                    n_state = i_stat.free_zero ? S_CLEAR : S_DONE;
                end
            end
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    o_cmd.done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    `ASSERT_CLK(a_latch_idle, i_clk, i_rst_n, o_cmd.latch |-> !o_busy, "latch while busy")
    `ASSERT_CLK(a_done_idle, i_clk, i_rst_n, o_cmd.done |=> !o_busy, "done not to idle")
    `ASSERT_CLK(a_state_range, i_clk, i_rst_n, r_state <= S_DONE, "bad state code")
endmodule
`default_nettype wire

// ----- hw/rtl/p2ba_dp.sv -----
// Datapath of the allocator: class heads, page table, link memory, count.
// Depends on p2ba_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module p2ba_dp #(
    parameter int PAGE_BYTES = 4096,
    parameter int POOL_PAGES = 64,
    parameter int MIN_BLOCK_LOG2 = 4,
    parameter int POINTER_BYTES = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_mode,
    input  wire logic [12:0]          i_request_bytes,
    input  wire logic [17:0]          i_block_address,
    input  p2ba_pkg::t_cmd            i_cmd,
    output p2ba_pkg::t_stat           o_stat,
    output logic                      o_strobe,
    output logic [17:0]               o_granted_address,
    output logic [1:0]                o_status,
    output logic                      o_pool_released
);
    localparam int PAGE_LOG2 = $clog2(PAGE_BYTES);
    localparam int LINK_DEPTH = (POOL_PAGES * PAGE_BYTES) >> MIN_BLOCK_LOG2;
    localparam int IDX_W = $clog2(LINK_DEPTH);
    localparam int PTR_W = IDX_W + 1;
    localparam int PG_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int PGC_W = $clog2(POOL_PAGES + 1);
    localparam int OFF_W = PAGE_LOG2 - MIN_BLOCK_LOG2 + 1;
    localparam int CW = p2ba_pkg::CLASS_W;
    localparam int NC = p2ba_pkg::MAX_CLASSES;
    localparam int KW = p2ba_pkg::COUNT_W;
    localparam logic [KW-1:0] COUNT_MAX = {KW{1'b1}};

    logic              r_mode;
    logic [12:0]       r_size;
    logic [17:0]       r_addr;
    logic [CW-1:0]     r_cls;
    logic [PTR_W-1:0]  r_head [NC];
    logic [CW:0]       r_pcls [POOL_PAGES];
    logic [CW:0]       r_pcls_q;
    logic [PTR_W-1:0]  r_link [LINK_DEPTH];
    logic [PTR_W-1:0]  r_link_q;
    logic [KW-1:0]     r_count;
    logic [PGC_W-1:0]  r_page;
    logic [PGC_W-1:0]  r_used;
    logic [OFF_W-1:0]  r_off;
    logic [OFF_W-1:0]  r_bcnt;
    logic              r_strobe;
    logic [17:0]       r_gaddr;
    logic [1:0]        r_status;
    logic              r_rel;
    logic              r_grant;
    logic [17:0]       r_out_addr;

    logic [13:0]       w_total;
    logic [12:0]       w_size1;
    logic [13:0]       w_bsize;
    logic [PG_W-1:0]   w_pidx;
    logic [IDX_W-1:0]  w_cut_idx;
    logic [17:0]       w_fpage;
    logic [CW:0]       w_fcls;
    logic [IDX_W-1:0]  w_free_idx;
    logic [17:0]       w_fmask;
    logic [PTR_W-1:0]  w_hd;

    // Pages are claimed lowest first and only released all together, so the
    // assigned pages are always pages zero up to r_used minus one.
    assign w_total = 14'(r_size) + 14'(POINTER_BYTES);
    assign w_size1 = (r_size == '0) ? 13'd1 : r_size;
    assign w_bsize = 14'(1) << (MIN_BLOCK_LOG2 + 32'(r_cls));
    assign w_pidx = r_page[PG_W-1:0];
    assign w_hd = r_head[r_cls];
    assign w_cut_idx = IDX_W'((32'(w_pidx) << (PAGE_LOG2 - MIN_BLOCK_LOG2))
                       + (32'(r_off) << r_cls));
    assign w_fpage = r_addr >> PAGE_LOG2;
    assign w_fcls = (w_fpage < 18'(r_used)) ? r_pcls_q : '0;
    assign w_fmask = ~((18'(1) << (MIN_BLOCK_LOG2 + 32'(w_fcls) - 1)) - 18'd1);
    assign w_free_idx = IDX_W'((r_addr & w_fmask) >> MIN_BLOCK_LOG2);

    always_comb begin
        o_stat = '0;
        o_stat.mode = r_mode;
        o_stat.too_large = (w_total > 14'(PAGE_BYTES));
        o_stat.class_found = (w_bsize >= 14'(w_size1)) || (r_cls == CW'(NC - 1));
        o_stat.head_empty = (w_hd == '0);
        o_stat.page_hit = (r_used < PGC_W'(POOL_PAGES));
        o_stat.page_end = (r_used >= PGC_W'(POOL_PAGES));
        o_stat.cut_last = (r_off == r_bcnt - OFF_W'(1));
        o_stat.free_bad = (w_fcls == '0);
        o_stat.free_zero = (r_count <= KW'(1));
        o_stat.clear_last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.link_read) begin
            r_link_q <= r_link[IDX_W'(w_hd - PTR_W'(1))];
        end
        if (i_cmd.cut_step) begin
            r_link[w_cut_idx] <= w_hd;
        end else if (i_cmd.free_push) begin
            r_link[w_free_idx] <= r_head[w_fcls[CW-1:0] - CW'(1)];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pcls_q <= r_pcls[w_fpage[PG_W-1:0]];
        if (i_cmd.claim_page) begin
            r_pcls[r_used[PG_W-1:0]] <= {1'b0, r_cls} + (CW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_mode;
            r_size <= i_request_bytes;
            r_addr <= i_block_address;
        end
        if (i_cmd.claim_page) begin
            r_bcnt <= OFF_W'((PAGE_BYTES >> MIN_BLOCK_LOG2) >> r_cls);
        end
        r_gaddr <= 18'(32'(w_hd - PTR_W'(1)) << MIN_BLOCK_LOG2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NC; c++) begin
                r_head[c] <= '0;
            end
            r_count <= '0;
            r_cls <= '0;
            r_page <= '0;
            r_used <= '0;
            r_off <= '0;
            r_strobe <= 1'b0;
            r_status <= p2ba_pkg::ST_OK;
            r_rel <= 1'b0;
        end else begin
            r_strobe <= i_cmd.done;
            if (i_cmd.latch) begin
                r_cls <= '0;
                r_off <= '0;
            end
            if (i_cmd.find_class && !o_stat.class_found) begin
                r_cls <= r_cls + CW'(1);
            end
            if (i_cmd.claim_page) begin
                r_page <= r_used;
                r_used <= r_used + PGC_W'(1);
                r_off <= '0;
            end
            if (i_cmd.cut_step) begin
                r_head[r_cls] <= PTR_W'(w_cut_idx) + PTR_W'(1);
                r_off <= r_off + OFF_W'(1);
            end
            if (i_cmd.pop) begin
                r_head[r_cls] <= r_link_q;
                if (r_count != COUNT_MAX) begin
                    r_count <= r_count + KW'(1);
                end
            end
            if (i_cmd.free_push) begin
                r_head[w_fcls[CW-1:0] - CW'(1)] <= PTR_W'(w_free_idx) + PTR_W'(1);
                if (r_count != '0) begin
                    r_count <= r_count - KW'(1);
                end
            end
            if (i_cmd.clear_step) begin
                r_used <= '0;
                for (int c = 0; c < NC; c++) begin
                    r_head[c] <= '0;
                end
                r_count <= '0;
            end
            if (i_cmd.done) begin
                r_rel <= i_cmd.clear_step;
                if (r_mode) begin
                    r_status <= (!i_cmd.clear_step && o_stat.free_bad)
                                ? p2ba_pkg::ST_BAD_FREE : p2ba_pkg::ST_OK;
                end else if (o_stat.too_large) begin
                    r_status <= p2ba_pkg::ST_TOO_LARGE;
                end else if (i_cmd.scan_page) begin
                    r_status <= p2ba_pkg::ST_NO_PAGE;
                end else begin
                    r_status <= p2ba_pkg::ST_OK;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grant <= 1'b0;
        end else if (i_cmd.pop) begin
            r_grant <= 1'b1;
        end else if (i_cmd.done) begin
            r_grant <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            r_out_addr <= r_grant ? r_gaddr : '0;
        end
    end

    assign o_strobe = r_strobe;
    assign o_granted_address = r_out_addr;
    assign o_status = r_status;
    assign o_pool_released = r_rel;

    `ASSERT_CLK(a_rel_ok, i_clk, i_rst_n,
        o_strobe && o_pool_released |-> o_status == p2ba_pkg::ST_OK, "release with error")
    `ASSERT_CLK(a_addr_zero, i_clk, i_rst_n,
        o_strobe && o_status != p2ba_pkg::ST_OK |-> o_granted_address == '0, "address on error")
    `ASSERT_CLK(a_pop_nonempty, i_clk, i_rst_n, i_cmd.pop |-> !o_stat.head_empty, "pop of empty list")
endmodule
`default_nettype wire

// ----- hw/rtl/power_of_two_block_allocator.sv -----
// Top level of the power-of-two block allocator: controller plus datapath.
// Depends on p2ba_pkg, p2ba_ctrl and p2ba_dp.
//
// Channel  | Handshake          | Ports
// request  | start, busy        | i_mode, i_request_bytes, i_block_address
// result   | o_done (one cycle) | o_granted_address, o_status, o_pool_released
//
// Each request is decoded first. An allocate from a nonempty list then searches
// the classes (one step per class above the smallest), reads the link and pops;
// a good free pushes, then clears if releasing. An empty class adds a scan and
// a cut per new page block (PAGE_BYTES >> MIN_BLOCK_LOG2 in the smallest class).
// Reset is synchronous; results cannot be stalled.
`default_nettype none
module power_of_two_block_allocator #(
    parameter int PAGE_BYTES = 4096,
    parameter int POOL_PAGES = 64,
    parameter int MIN_BLOCK_LOG2 = 4,
    parameter int POINTER_BYTES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_mode,
    input  wire logic [12:0] i_request_bytes,
    input  wire logic [17:0] i_block_address,
    output logic             o_done,
    output logic [17:0]      o_granted_address,
    output logic [1:0]       o_status,
    output logic             o_pool_released
);
    p2ba_pkg::t_cmd  w_cmd;
    p2ba_pkg::t_stat w_stat;

    p2ba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    p2ba_dp #(
        .PAGE_BYTES     (PAGE_BYTES),
        .POOL_PAGES     (POOL_PAGES),
        .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
        .POINTER_BYTES  (POINTER_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_mode            (i_mode),
        .i_request_bytes   (i_request_bytes),
        .i_block_address   (i_block_address),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_strobe          (o_done),
        .o_granted_address (o_granted_address),
        .o_status          (o_status),
        .o_pool_released   (o_pool_released)
    );
endmodule
`default_nettype wire
